@@ rtl/core/triangle_clip_cull_project_macros.svh @@
// ----------------------------------------------------------------------------
// triangle_clip_cull_project assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CLIP_CULL_PROJECT_MACROS_SVH
`define TRIANGLE_CLIP_CULL_PROJECT_MACROS_SVH
// implication under reset
`define TCC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("tcc check failed");
// next-cycle implication under reset
`define TCC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("tcc check failed");
`endif

@@ rtl/core/tcc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcc_pkg
// Types and constants for the triangle clip/cull/project block.
// ----------------------------------------------------------------------------
`default_nettype none
package tcc_pkg;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [1:0] CFG_NEAR = 2'd0;
	localparam logic [1:0] CFG_FAR = 2'd1;
	localparam logic [1:0] CFG_CULL = 2'd2;
	localparam logic [1:0] SEL_PROJ = 2'd0;
	localparam logic [1:0] SEL_VIEW = 2'd1;
	localparam logic [1:0] SEL_NORM = 2'd2;
	localparam logic OP_LOAD = 1'b0;
	localparam logic [1:0] CULL_NEG = 2'd1;
	localparam logic [1:0] CULL_POS = 2'd0;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PROJ, ST_PROJ_W, ST_CHECK, ST_NDIV, ST_NDIV_W,
		ST_AREA, ST_AREA_W, ST_CULL, ST_VIEW, ST_VIEW_W, ST_SDIV, ST_SDIV_W,
		ST_EMIT, ST_EMIT_W
	} state_t;

	// matvec unit matrix source
	typedef enum logic [1:0] {
		MV_PROJ, MV_VIEW, MV_NORM
	} mv_src_t;

	typedef struct packed {
		logic       mv_start;
		mv_src_t    mv_src;
		logic [1:0] vtx;
		logic       div_start;
		logic [2:0] div_sel;
		logic       area_start;
		logic       area_clr;
		logic       emit;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic mv_done;
		logic div_done;
		logic area_done;
		logic reject;
		logic cull;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/core/tcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer for one triangle: projection, clip test, divides, area, cull, transforms, output.
// ----------------------------------------------------------------------------
`default_nettype none
module tcc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output tcc_pkg::cmd_t       cmd,
	input  tcc_pkg::sts_t       sts,
	input  wire logic           out_free
);
	import tcc_pkg::*;
	state_t st_q, st_nx;
	logic [1:0] k_q, k_nx;
	logic [2:0] d_q, d_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q <= '0;
			d_q <= '0;
		end else begin
			st_q <= st_nx;
			k_q <= k_nx;
			d_q <= d_nx;
		end
	end

	always_comb begin
		st_nx = st_q;
		k_nx = k_q;
		d_nx = d_q;
		cmd = '0;
		cmd.vtx = k_q;
		cmd.div_sel = d_q;
		cmd.mv_src = MV_PROJ;
		busy = (st_q != ST_IDLE);
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					st_nx = ST_PROJ;
					k_nx = '0;
				end
			end
			ST_PROJ: begin
				cmd.mv_start = 1'b1;
				st_nx = ST_PROJ_W;
			end
			ST_PROJ_W: begin
				if (sts.mv_done) st_nx = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.reject) st_nx = ST_IDLE;
				else if (k_q == 2'd2) begin
					k_nx = '0;
					d_nx = '0;
					st_nx = ST_NDIV;
				end else begin
					k_nx = k_q + 2'd1;
					st_nx = ST_PROJ;
				end
			end
			ST_NDIV: begin
				cmd.div_start = 1'b1;
				st_nx = ST_NDIV_W;
			end
			ST_NDIV_W: begin
				if (sts.div_done) begin
					if (d_q == 3'd0) begin
						d_nx = 3'd1;
						st_nx = ST_NDIV;
					end else if (k_q == 2'd2) begin
						k_nx = '0;
						d_nx = 3'd0;
						st_nx = ST_AREA;
					end else begin
						d_nx = 3'd0;
						k_nx = k_q + 2'd1;
						st_nx = ST_NDIV;
					end
				end
			end
			ST_AREA: begin
				cmd.area_start = 1'b1;
				cmd.area_clr = (k_q == 2'd0);
				st_nx = ST_AREA_W;
			end
			ST_AREA_W: begin
				if (sts.area_done) begin
					if (k_q == 2'd2) begin
						k_nx = '0;
						st_nx = ST_CULL;
					end else begin
						k_nx = k_q + 2'd1;
						st_nx = ST_AREA;
					end
				end
			end
			ST_CULL: begin
				st_nx = sts.cull ? ST_IDLE : ST_VIEW;
			end
			ST_VIEW: begin
				cmd.mv_src = d_q[0] ? MV_NORM : MV_VIEW;
				cmd.mv_start = 1'b1;
				st_nx = ST_VIEW_W;
			end
			ST_VIEW_W: begin
				cmd.mv_src = d_q[0] ? MV_NORM : MV_VIEW;
				if (sts.mv_done) begin
					if (d_q[0]) begin
						d_nx = 3'd2;
						st_nx = ST_SDIV;
					end else begin
						d_nx = 3'd1;
						st_nx = ST_VIEW;
					end
				end
			end
			ST_SDIV: begin
				cmd.div_start = 1'b1;
				st_nx = ST_SDIV_W;
			end
			ST_SDIV_W: begin
				if (sts.div_done) begin
					if (d_q == 3'd5) st_nx = ST_EMIT;
					else begin
						d_nx = d_q + 3'd1;
						st_nx = ST_SDIV;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					cmd.last = (k_q == 2'd2);
					d_nx = 3'd0;
					if (k_q == 2'd2) st_nx = ST_IDLE;
					else begin
						k_nx = k_q + 2'd1;
						st_nx = ST_VIEW;
					end
				end
			end
			default: st_nx = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/tcc_datapath.sv @@
// ----------------------------------------------------------------------------
// tcc_datapath
// Matrices, vertex buffer, shared multiply-accumulate and divider units.
// ----------------------------------------------------------------------------
`default_nettype none
module tcc_datapath #(
	parameter int CW = 32,
	parameter int FB = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ld_we,
	input  wire logic [1:0]         ld_sel,
	input  wire logic [3:0]         ld_idx,
	input  wire logic signed [CW-1:0] ld_val,
	input  wire logic               vtx_we,
	input  wire logic [1:0]         vtx_slot,
	input  wire logic signed [CW-1:0] pos_in [4],
	input  wire logic signed [CW-1:0] nrm_in [4],
	input  wire logic signed [CW-1:0] near_q,
	input  wire logic signed [CW-1:0] far_q,
	input  wire logic [1:0]         cull_q,
	input  tcc_pkg::cmd_t           cmd,
	output tcc_pkg::sts_t           sts,
	output logic signed [31:0]      o_flds [9]
);
	import tcc_pkg::*;
	localparam int PW = 2 * CW;
	localparam int AW = PW + 3;
	localparam int NW = CW + FB;
	localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

	logic signed [CW-1:0] pm_q [16];
	logic signed [CW-1:0] vm_q [16];
	logic signed [CW-1:0] nm_q [16];
	logic signed [CW-1:0] pos_q [3][4];
	logic signed [CW-1:0] nrm_q [3][4];
	logic signed [CW-1:0] clip_q [3][4];
	logic signed [CW-1:0] vec_q [4];
	logic signed [CW-1:0] nx_q [3];
	logic signed [CW-1:0] ny_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				pm_q[i] <= '0;
				vm_q[i] <= '0;
				nm_q[i] <= '0;
			end
		end else if (ld_we) begin
			if (ld_sel == SEL_PROJ) pm_q[ld_idx] <= ld_val;
			else if (ld_sel == SEL_VIEW) vm_q[ld_idx] <= ld_val;
			else if (ld_sel == SEL_NORM) nm_q[ld_idx] <= ld_val;
		end
	end

	always_ff @(posedge clk) begin
		if (vtx_we) begin
			for (int j = 0; j < 4; j++) begin
				pos_q[vtx_slot][j] <= pos_in[j];
				nrm_q[vtx_slot][j] <= nrm_in[j];
			end
		end
	end

	// ---- matrix-vector unit: one product per cycle ----
	logic mv_busy_q, mv_done_q;
	logic [3:0] mv_cnt_q;
	mv_src_t mv_src_q;
	logic signed [CW-1:0] ma, va;
	logic signed [PW-1:0] prod_s1;
	logic prod_v_s1, prod_end_s1;
	logic [1:0] prod_row_s1;
	// column position of the product in stage 1
	logic [1:0] col_s1;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] acc_nx;
	logic signed [AW-FB-1:0] acc_sh;
	logic signed [CW-1:0] row_sat;
	logic signed [CW-1:0] mvec [4];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			unique case (cmd.mv_src)
				MV_PROJ: mvec[j] = pos_q[cmd.vtx][j];
				MV_VIEW: mvec[j] = clip_q[cmd.vtx][j];
				default: mvec[j] = nrm_q[cmd.vtx][j];
			endcase
		end
		unique case (mv_src_q)
			MV_PROJ: ma = pm_q[mv_cnt_q];
			MV_VIEW: ma = vm_q[mv_cnt_q];
			default: ma = nm_q[mv_cnt_q];
		endcase
		va = vec_q[mv_cnt_q[1:0]];
		acc_nx = ((col_s1 == 2'd0) ? AW'(0) : acc_q) + AW'(prod_s1);
		acc_sh = acc_nx[AW-1:FB];
		if (acc_sh > (AW-FB)'(SMAX)) row_sat = SMAX;
		else if (acc_sh < (AW-FB)'(SMIN)) row_sat = SMIN;
		else row_sat = acc_sh[CW-1:0];
	end

	logic signed [CW-1:0] res_q [4];
	logic [1:0] res_ptr;
	assign res_ptr = prod_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_busy_q <= 1'b0;
			mv_done_q <= 1'b0;
			mv_cnt_q <= '0;
			prod_v_s1 <= 1'b0;
			prod_end_s1 <= 1'b0;
			mv_src_q <= MV_PROJ;
		end else begin
			mv_done_q <= 1'b0;
			prod_v_s1 <= mv_busy_q;
			prod_end_s1 <= mv_busy_q && (mv_cnt_q == 4'd15);
			if (cmd.mv_start) begin
				mv_busy_q <= 1'b1;
				mv_cnt_q <= '0;
				mv_src_q <= cmd.mv_src;
			end else if (mv_busy_q) begin
				mv_cnt_q <= mv_cnt_q + 4'd1;
				if (mv_cnt_q == 4'd15) mv_busy_q <= 1'b0;
			end
			if (prod_end_s1) mv_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mv_start) begin
			for (int j = 0; j < 4; j++) vec_q[j] <= mvec[j];
		end
		prod_s1 <= ma * va;
		prod_row_s1 <= mv_cnt_q[3:2];
		col_s1 <= mv_cnt_q[1:0];
		if (prod_v_s1) begin
			acc_q <= acc_nx;
			if (col_s1 == 2'd3) res_q[res_ptr] <= row_sat;
		end
	end

	// capture clip result after projection
	logic mv_src_view_d;
	always_ff @(posedge clk) begin
		if (mv_done_q && mv_src_q == MV_PROJ)
			for (int j = 0; j < 4; j++) clip_q[cmd.vtx][j] <= res_q[j];
	end
	assign mv_src_view_d = (mv_src_q == MV_VIEW);

	logic signed [CW-1:0] sv_q [4];
	logic signed [CW-1:0] nt_q [4];
	always_ff @(posedge clk) begin
		if (mv_done_q && mv_src_view_d) for (int j = 0; j < 4; j++) sv_q[j] <= res_q[j];
		if (mv_done_q && mv_src_q == MV_NORM) for (int j = 0; j < 4; j++) nt_q[j] <= res_q[j];
	end

	// ---- clip test ----
	logic signed [CW-1:0] cx, cz, cw;
	logic [CW-1:0] ax, aw;
	always_comb begin
		cx = res_q[0];
		cz = res_q[2];
		cw = res_q[3];
		ax = cx[CW-1] ? -cx : cx;
		aw = cw[CW-1] ? -cw : cw;
	end
	logic rej_q;
	always_ff @(posedge clk) begin
		if (mv_done_q)
			rej_q <= (cw <= 0) || (cz <= near_q) || (cz >= far_q) || (ax >= aw);
	end

	// ---- divider: restoring, one bit per cycle ----
	logic signed [CW-1:0] dn, dd;
	always_comb begin
		unique case (cmd.div_sel)
			3'd0: begin dn = clip_q[cmd.vtx][0]; dd = clip_q[cmd.vtx][3]; end
			3'd1: begin dn = clip_q[cmd.vtx][1]; dd = clip_q[cmd.vtx][3]; end
			3'd2: begin dn = sv_q[0]; dd = sv_q[3]; end
			3'd3: begin dn = sv_q[1]; dd = sv_q[3]; end
			3'd4: begin dn = sv_q[2]; dd = sv_q[3]; end
			3'd5: begin dn = clip_q[cmd.vtx][2]; dd = clip_q[cmd.vtx][3]; end
			default: begin dn = '0; dd = '0; end
		endcase
	end

	localparam int DCW = $clog2(NW + 1);
	logic dv_busy_q, dv_done_q, dv_neg_q, dv_zero_q, dv_npos_q;
	logic [DCW-1:0] dv_cnt_q;
	logic [NW-1:0] dv_num_q, dv_quo_q;
	logic [CW:0] dv_rem_q, dv_den_q;
	logic [CW:0] rem_sh;
	logic [CW-1:0] un, ud;
	logic signed [NW:0] q_signed;
	logic signed [CW-1:0] div_res;
	assign un = dn[CW-1] ? -dn : dn;
	assign ud = dd[CW-1] ? -dd : dd;
	assign rem_sh = {dv_rem_q[CW-1:0], dv_num_q[NW-1]};
	always_comb begin
		q_signed = dv_neg_q ? -$signed({1'b0, dv_quo_q}) : $signed({1'b0, dv_quo_q});
		if (dv_zero_q) div_res = dv_npos_q ? SMAX : (dv_neg_q ? SMIN : '0);
		else if (q_signed > (NW+1)'(SMAX)) div_res = SMAX;
		else if (q_signed < (NW+1)'(SMIN)) div_res = SMIN;
		else div_res = q_signed[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_done_q <= 1'b0;
		end else begin
			dv_done_q <= 1'b0;
			if (cmd.div_start) begin
				dv_busy_q <= (dd != '0);
				dv_done_q <= (dd == '0);
			end else if (dv_busy_q && dv_cnt_q == DCW'(NW - 1)) begin
				dv_busy_q <= 1'b0;
				dv_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dv_cnt_q <= '0;
			dv_num_q <= {un, {FB{1'b0}}};
			dv_den_q <= {1'b0, ud};
			dv_rem_q <= '0;
			dv_quo_q <= '0;
			dv_zero_q <= (dd == '0);
			dv_npos_q <= (dd == '0) && !dn[CW-1] && (dn != '0);
			dv_neg_q <= (dd == '0) ? dn[CW-1] : (dn[CW-1] ^ dd[CW-1]);
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q + DCW'(1);
			dv_num_q <= {dv_num_q[NW-2:0], 1'b0};
			if (rem_sh >= dv_den_q) begin
				dv_rem_q <= rem_sh - dv_den_q;
				dv_quo_q <= {dv_quo_q[NW-2:0], 1'b1};
			end else begin
				dv_rem_q <= rem_sh;
				dv_quo_q <= {dv_quo_q[NW-2:0], 1'b0};
			end
		end
	end

	logic signed [CW-1:0] sq_q [4];
	always_ff @(posedge clk) begin
		if (dv_done_q) begin
			unique case (cmd.div_sel)
				3'd0: nx_q[cmd.vtx] <= div_res;
				3'd1: ny_q[cmd.vtx] <= div_res;
				3'd2: sq_q[0] <= div_res;
				3'd3: sq_q[1] <= div_res;
				3'd4: sq_q[2] <= div_res;
				default: sq_q[3] <= div_res;
			endcase
		end
	end

	// ---- signed area: two products per vertex ----
	localparam int AR = PW + 3;
	logic signed [AR-1:0] area_q;
	logic signed [PW-1:0] ap_s1;
	logic [1:0] ar_ph_q;
	logic ar_done_q;
	logic [1:0] kn;
	assign kn = (cmd.vtx == 2'd2) ? 2'd0 : cmd.vtx + 2'd1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ar_ph_q <= '0;
			ar_done_q <= 1'b0;
		end else begin
			ar_done_q <= 1'b0;
			if (cmd.area_start) ar_ph_q <= 2'd1;
			else if (ar_ph_q == 2'd1) ar_ph_q <= 2'd2;
			else if (ar_ph_q == 2'd2) ar_ph_q <= 2'd3;
			else if (ar_ph_q == 2'd3) begin
				ar_ph_q <= 2'd0;
				ar_done_q <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.area_start && cmd.area_clr) area_q <= '0;
		if (ar_ph_q == 2'd1) ap_s1 <= nx_q[cmd.vtx] * ny_q[kn];
		if (ar_ph_q == 2'd2) begin
			ap_s1 <= nx_q[kn] * ny_q[cmd.vtx];
			area_q <= area_q + AR'(ap_s1);
		end
		if (ar_ph_q == 2'd3) area_q <= area_q - AR'(ap_s1);
	end

	always_comb begin
		sts.mv_done = mv_done_q;
		sts.div_done = dv_done_q;
		sts.area_done = ar_done_q;
		sts.reject = rej_q;
		sts.cull = ((cull_q == CULL_NEG) && area_q[AR-1])
			|| ((cull_q == CULL_POS) && !area_q[AR-1] && (area_q != '0));
	end

	function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
		logic signed [CW+32:0] e;
		e = (CW+33)'(v);
		if (e > (CW+33)'(33'sh07fffffff)) sat32 = 32'sh7fffffff;
		else if (e < -(CW+33)'(33'sh080000000)) sat32 = 32'sh80000000;
		else sat32 = e[31:0];
	endfunction

	always_comb begin
		o_flds[0] = sat32(sq_q[0]);
		o_flds[1] = sat32(sq_q[1]);
		o_flds[2] = sat32(sq_q[2]);
		o_flds[3] = sat32(sv_q[3]);
		o_flds[4] = sat32(sq_q[3]);
		for (int j = 0; j < 4; j++) o_flds[5+j] = sat32(nt_q[j]);
	end
endmodule
`default_nettype wire

@@ rtl/core/triangle_clip_cull_project.sv @@
// ----------------------------------------------------------------------------
// triangle_clip_cull_project
// Two vertices are buffered; the third triggers projection, clip test, cull by
// area sign, then viewport/normal transforms and divides. A load or buffered
// vertex is taken while in_stall is low. A triangle holds the input stalled
// while one shared MAC and one bit-per-cycle divider are reused: three
// projections with clip checks, two NDC divides and an area step per vertex,
// then per surviving vertex two matrix products, four divides and the output
// transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_clip_cull_project #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [1:0]  matrix_select,
	input  wire logic [3:0]  matrix_index,
	input  wire logic signed [31:0] matrix_value,
	input  wire logic signed [31:0] eye_x,
	input  wire logic signed [31:0] eye_y,
	input  wire logic signed [31:0] eye_z,
	input  wire logic signed [31:0] eye_w,
	input  wire logic signed [31:0] normal_in_x,
	input  wire logic signed [31:0] normal_in_y,
	input  wire logic signed [31:0] normal_in_z,
	input  wire logic signed [31:0] normal_in_w,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic signed [31:0] screen_z,
	output logic signed [31:0] screen_w,
	output logic signed [31:0] ndc_z,
	output logic signed [31:0] normal_out_x,
	output logic signed [31:0] normal_out_y,
	output logic signed [31:0] normal_out_z,
	output logic signed [31:0] normal_out_w,
	output logic             last_vertex
);
	import tcc_pkg::*;
	localparam int CW = COORD_WIDTH;

	function automatic logic signed [CW-1:0] inw(input logic signed [31:0] v);
		logic signed [48:0] e;
		e = 49'(v);
		if (e > $signed(49'({1'b0, {(CW-1){1'b1}}}))) inw = {1'b0, {(CW-1){1'b1}}};
		else if (e < -49'(49'sd1 <<< (CW-1))) inw = {1'b1, {(CW-1){1'b0}}};
		else inw = e[CW-1:0];
	endfunction

	logic signed [CW-1:0] near_q, far_q;
	logic [1:0] cull_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= CW'(6554);
			far_q <= CW'(6553600);
			cull_q <= CULL_NEG;
		end else if (cfg_we) begin
			if (cfg_index == CFG_NEAR) near_q <= inw(cfg_data);
			else if (cfg_index == CFG_FAR) far_q <= inw(cfg_data);
			else if (cfg_index == CFG_CULL) cull_q <= cfg_data[1:0];
		end
	end

	logic busy;
	cmd_t cmd;
	sts_t sts;
	logic [1:0] phase_q;
	logic acc;
	logic signed [CW-1:0] pos_in [4];
	logic signed [CW-1:0] nrm_in [4];
	logic signed [31:0] fl [9];

	assign in_stall = busy;
	assign acc = in_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) phase_q <= '0;
		else if (acc && opcode != OP_LOAD)
			phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
	end

	always_comb begin
		pos_in[0] = inw(eye_x);
		pos_in[1] = inw(eye_y);
		pos_in[2] = inw(eye_z);
		pos_in[3] = inw(eye_w);
		nrm_in[0] = inw(normal_in_x);
		nrm_in[1] = inw(normal_in_y);
		nrm_in[2] = inw(normal_in_z);
		nrm_in[3] = inw(normal_in_w);
	end

	logic out_free;
	assign out_free = !out_valid || !out_stall;

	tcc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.start(acc && opcode != OP_LOAD && phase_q == 2'd2),
		.busy(busy), .cmd(cmd), .sts(sts), .out_free(out_free)
	);

	tcc_datapath #(.CW(CW), .FB(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.ld_we(acc && opcode == OP_LOAD), .ld_sel(matrix_select),
		.ld_idx(matrix_index), .ld_val(inw(matrix_value)),
		.vtx_we(acc && opcode != OP_LOAD), .vtx_slot(phase_q),
		.pos_in(pos_in), .nrm_in(nrm_in),
		.near_q(near_q), .far_q(far_q), .cull_q(cull_q),
		.cmd(cmd), .sts(sts), .o_flds(fl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			screen_x <= fl[0];
			screen_y <= fl[1];
			screen_z <= fl[2];
			screen_w <= fl[3];
			ndc_z <= fl[4];
			normal_out_x <= fl[5];
			normal_out_y <= fl[6];
			normal_out_z <= fl[7];
			normal_out_w <= fl[8];
			last_vertex <= cmd.last;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/tcc_checker.sv @@
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks for triangle_clip_cull_project.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_clip_cull_project_macros.svh"
module tcc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic opcode,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic last_vertex
);
	`TCC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`TCC_ASSERT_NXT(a_last_hold, clk, arst_n, out_valid && out_stall, $stable(last_vertex))
	`TCC_ASSERT_NXT(a_load_no_stall, clk, arst_n, in_valid && !in_stall && !opcode, !in_stall)
	`TCC_ASSERT_IMP(a_out_busy, clk, arst_n, out_valid && !last_vertex, in_stall)
endmodule
bind triangle_clip_cull_project tcc_checker u_tcc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.opcode(opcode), .out_valid(out_valid), .out_stall(out_stall),
	.last_vertex(last_vertex)
);
`default_nettype wire
